### rtl/tlfd_pkg.sv
// ----------------------------------------------------------------------------
// tlfd_pkg
// Types and codes shared by the type-length frame deframer modules.
// ----------------------------------------------------------------------------
package tlfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 24;
    localparam int LEFT_W  = 21;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 2;
    localparam int INDEX_W = 2;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TYPE     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LENGTH   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNCATE = 2'd3;

    localparam logic [INDEX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [INDEX_W-1:0] REG_TYPE_LOW    = 2'd1;
    localparam logic [INDEX_W-1:0] REG_TYPE_HIGH   = 2'd2;

    typedef struct packed {
        logic [LEFT_W-1:0] len_limit;
        logic [BYTE_W-1:0] type_low;
        logic [BYTE_W-1:0] type_high;
    } tlfd_cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_frame;
        logic [ERR_W-1:0]  error_code;
    } tlfd_result_t;

endpackage

### rtl/tlfd_cfg.sv
// ----------------------------------------------------------------------------
// tlfd_cfg
// Configuration register file: payload cap and accepted type range.
// ----------------------------------------------------------------------------
module tlfd_cfg
    import tlfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [LEFT_W-1:0]  cfg_data,
    output tlfd_cfg_t          cfg
);

    tlfd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.len_limit <= LEFT_W'(1048576);
            cfg_reg.type_low  <= 8'd1;
            cfg_reg.type_high <= 8'd10;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_PAYLOAD: cfg_reg.len_limit <= cfg_data;
                REG_TYPE_LOW:    cfg_reg.type_low  <= cfg_data[BYTE_W-1:0];
                REG_TYPE_HIGH:   cfg_reg.type_high <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/tlfd_parse.sv
// ----------------------------------------------------------------------------
// tlfd_parse
// Frame parser: header shift, type and length check, payload counter, sticky error.
// ----------------------------------------------------------------------------
module tlfd_parse
    import tlfd_pkg::*;
#(
    parameter int PAYLOAD_CAP = 1048576
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tlfd_cfg_t         cfg,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_data,
    input  logic              in_end,
    output logic              res_valid,
    output tlfd_result_t      res
);

    localparam logic [LEN_W-1:0] CAP_LIMIT = LEN_W'(PAYLOAD_CAP);

    logic [1:0]          hdr_count_reg, hdr_count_next;
    logic [LEN_W-1:0]    hdr_bytes_reg, hdr_bytes_next;
    logic [LEFT_W-1:0]   left_reg,      left_next;
    logic [BYTE_W-1:0]   cur_type_reg,  cur_type_next;
    logic                failed_reg,    failed_next;

    logic [BYTE_W-1:0]   hdr_type;
    logic [LEN_W-1:0]    hdr_len;
    logic [LEN_W-1:0]    cap_reg_ext;
    logic [LEN_W-1:0]    cap_eff;

    assign hdr_type    = hdr_bytes_reg[LEN_W-1:LEN_W-BYTE_W];
    assign hdr_len     = {hdr_bytes_reg[LEN_W-BYTE_W-1:0], in_data};
    assign cap_reg_ext = LEN_W'(cfg.len_limit);
    assign cap_eff     = (cap_reg_ext < CAP_LIMIT) ? cap_reg_ext : CAP_LIMIT;

    always_comb begin
        hdr_count_next = hdr_count_reg;
        hdr_bytes_next = hdr_bytes_reg;
        left_next      = left_reg;
        cur_type_next  = cur_type_reg;
        failed_next    = failed_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (in_accept && !failed_reg) begin
            if (in_end) begin
                res_valid = 1'b1;
                if (hdr_count_reg != 2'd0 || left_reg != '0) begin
                    failed_next    = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.frame_type = (left_reg != '0) ? cur_type_reg : '0;
                    res.error_code = ERR_TRUNCATE;
                end else begin
                    res.kind = KIND_END;
                end
            end else if (left_reg != '0) begin
                res_valid         = 1'b1;
                left_next         = left_reg - LEFT_W'(1);
                res.kind          = KIND_BYTE;
                res.frame_type    = cur_type_reg;
                res.payload_byte  = in_data;
                res.last_of_frame = (left_reg == LEFT_W'(1));
            end else if (hdr_count_reg != 2'd3) begin
                hdr_bytes_next = {hdr_bytes_reg[LEN_W-BYTE_W-1:0], in_data};
                hdr_count_next = hdr_count_reg + 2'd1;
            end else begin
                hdr_count_next = '0;
                hdr_bytes_next = '0;
                res_valid      = 1'b1;
                res.frame_type = hdr_type;
                if (hdr_type < cfg.type_low || hdr_type > cfg.type_high) begin
                    failed_next    = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TYPE;
                end else if (hdr_len > cap_eff) begin
                    failed_next    = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_LENGTH;
                end else begin
                    cur_type_next = hdr_type;
                    if (hdr_len == '0) begin
                        res.kind          = KIND_EMPTY;
                        res.last_of_frame = 1'b1;
                    end else begin
                        res_valid = 1'b0;
                        left_next = hdr_len[LEFT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_count_reg <= '0;
            hdr_bytes_reg <= '0;
            left_reg      <= '0;
            cur_type_reg  <= '0;
            failed_reg    <= 1'b0;
        end else begin
            hdr_count_reg <= hdr_count_next;
            hdr_bytes_reg <= hdr_bytes_next;
            left_reg      <= left_next;
            cur_type_reg  <= cur_type_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

### rtl/tlfd_out.sv
// ----------------------------------------------------------------------------
// tlfd_out
// Result register with a skid stage that takes one more result under backpressure.
// ----------------------------------------------------------------------------
module tlfd_out
    import tlfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         res_valid,
    input  tlfd_result_t res,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output tlfd_result_t out_res
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    tlfd_result_t out_reg;
    tlfd_result_t skid_reg;
    logic         out_free;

    assign out_free  = out_ready || !out_valid_reg;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

endmodule

### rtl/type_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// type_length_frame_deframer
// Cut-through deframer for a byte stream of type/length-prefixed frames.
// ----------------------------------------------------------------------------
// one byte or stream-end transfer is taken every cycle while s_tready is
// high; its result, if any, reaches the m_ side through the result register,
// via the skid stage when m_tready holds it back. header bytes and payload
// bytes are handled in a single pass through the header shift register and
// the payload down-counter, so the rate is one item per clock. s_tready drops
// only when both the result register and the skid stage hold results that
// m_tready has not taken. after an error the block drops all input until aresetn.
module type_length_frame_deframer
    import tlfd_pkg::*;
#(
    parameter int PAYLOAD_CAP = 1048576
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,     // data
    input  logic               s_tuser,     // stream_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,     // frame_type, payload_byte, error_code, zero pad
    output logic [1:0]         m_tuser,     // kind
    output logic               m_tlast,     // last_of_frame
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [LEFT_W-1:0]  cfg_data
);

    tlfd_cfg_t    cfg;
    tlfd_result_t res;
    tlfd_result_t out_res;
    logic         res_valid;
    logic         in_accept;

    assign in_accept = s_tvalid && s_tready;

    tlfd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlfd_parse #(
        .PAYLOAD_CAP (PAYLOAD_CAP)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_data   (s_tdata),
        .in_end    (s_tuser),
        .res_valid (res_valid),
        .res       (res)
    );

    tlfd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'd0, out_res.error_code, out_res.payload_byte, out_res.frame_type};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_of_frame;

endmodule
